// ===== design/assert_macros.svh =====
// Assertion macros shared by the cache RTL.
// Needs a clock named clk and a reset named rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// antecedent implies consequent in the same cycle
`define FLC_ASSERT_IMP(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// condition holds at every clock edge
`define FLC_ASSERT_ALW(label, c) \
  label: assert property (@(posedge clk) disable iff (rst) (c)) \
    else $error("assertion failed");
`endif

// ===== design/flc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the frame pinned LFU image cache: sizes, codes, types.
// No dependencies.
package flc_pkg;
  localparam int CACHE_ENTRIES = 256;
  localparam int IDX_W = $clog2(CACHE_ENTRIES);
  localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
  localparam int EVICT_MAX = 511;

  localparam logic [1:0] REQ_ACCESS = 2'd0;
  localparam logic [1:0] REQ_FRAME  = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  typedef struct packed {
    logic [63:0] key;
    logic [16:0] handle;
    logic [31:0] uses;
    logic [31:0] frame;
  } entry_t;

  typedef struct packed {
    logic simple;
    logic latch;
    logic scan_ck;
    logic idx_inc;
    logic idx_clr;
    logic hit_wr;
    logic ev_ck;
    logic ins;
  } cmd_t;

  typedef struct packed {
    logic is_access;
    logic match;
    logic last;
    logic full;
  } sts_t;

  function automatic logic [8:0] sat_evict(input logic [CNT_W-1:0] n);
    if (CNT_W > 9 && 32'(n) > 32'(EVICT_MAX)) begin
      sat_evict = 9'(EVICT_MAX);
    end else begin
      sat_evict = 9'(n);
    end
  endfunction
endpackage

// ===== design/flc_ram.sv =====
`timescale 1ns / 1ps
// Generic single write, single read RAM with registered read data.
// No dependencies.
module flc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/flc_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the cache: lookup scan, eviction pass, insert.
// Depends on flc_pkg.
module flc_ctrl import flc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RD   = 7'b0000010,
    S_CK   = 7'b0000100,
    S_HIT  = 7'b0001000,
    S_ERD  = 7'b0010000,
    S_ECK  = 7'b0100000,
    S_INS  = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (sts.is_access) begin
            cmd.latch = 1'b1;
            cmd.idx_clr = 1'b1;
            state_next = S_RD;
          end else begin
            cmd.simple = 1'b1;
          end
        end
      end
      S_RD: state_next = S_CK;
      S_CK: begin
        if (sts.match) begin
          state_next = S_HIT;
        end else begin
          cmd.scan_ck = 1'b1;
          if (!sts.last) begin
            cmd.idx_inc = 1'b1;
            state_next = S_RD;
          end else if (sts.full) begin
            cmd.idx_clr = 1'b1;
            state_next = S_ERD;
          end else begin
            state_next = S_INS;
          end
        end
      end
      S_HIT: begin
        cmd.hit_wr = 1'b1;
        state_next = S_IDLE;
      end
      S_ERD: state_next = S_ECK;
      S_ECK: begin
        cmd.ev_ck = 1'b1;
        if (sts.last) begin
          state_next = S_INS;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next = S_ERD;
        end
      end
      S_INS: begin
        cmd.ins = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// ===== design/flc_dp.sv =====
`timescale 1ns / 1ps
// Datapath: valid bits, entry RAM, scan index, minimum, frame and result registers.
// Depends on flc_pkg and flc_ram.
module flc_dp import flc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [1:0]         req_type,
  input  logic [63:0]        image_key,
  input  logic signed [16:0] new_handle,
  output logic               done,
  output logic               hit,
  output logic signed [16:0] handle_out,
  output logic [8:0]         evicted_count,
  output logic               stored,
  output logic [CNT_W-1:0]   total
);
  logic [CACHE_ENTRIES-1:0] valid;
  logic [63:0]      key_q;
  logic [16:0]      hdl_q;
  logic [IDX_W-1:0] idx;
  logic [31:0]      mn;
  logic             mn_have;
  logic [IDX_W-1:0] free;
  logic             free_ok;
  logic [CNT_W-1:0] removed;
  logic [31:0]      fn;
  entry_t           rdata, wdata, upd;
  logic             we;
  logic [IDX_W-1:0] waddr;

  flc_ram #(.WIDTH($bits(entry_t)), .DEPTH(CACHE_ENTRIES)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(idx), .rdata(rdata)
  );

  assign sts.is_access = (req_type == REQ_ACCESS);
  assign sts.match = valid[idx] && (rdata.key == key_q);
  assign sts.last = (idx == IDX_W'(CACHE_ENTRIES - 1));
  assign sts.full = (total == CNT_W'(CACHE_ENTRIES));

  always_comb begin
    upd = rdata;
    we = 1'b0;
    waddr = idx;
    if (cmd.hit_wr) begin
      if (rdata.uses != 32'hFFFF_FFFF) begin
        upd.uses = rdata.uses + 32'd1;
      end
      upd.frame = fn;
      we = 1'b1;
    end else if (cmd.ev_ck) begin
      upd.uses = rdata.uses - mn;
      we = valid[idx] && (rdata.frame != fn) && (rdata.uses != mn);
    end else if (cmd.ins) begin
      upd.key = key_q;
      upd.handle = hdl_q;
      upd.uses = 32'd1;
      upd.frame = fn;
      waddr = free;
      we = free_ok;
    end
    wdata = upd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      fn <= '0;
      total <= '0;
      done <= 1'b0;
      idx <= '0;
    end else begin
      done <= cmd.simple || cmd.hit_wr || cmd.ins;
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + IDX_W'(1);
      end
      if (cmd.simple) begin
        if (req_type == REQ_FRAME) begin
          fn <= fn + 32'd1;
        end else if (req_type == REQ_CLEAR) begin
          valid <= '0;
          total <= '0;
        end
      end
      if (cmd.ev_ck && valid[idx] && rdata.frame != fn && rdata.uses == mn) begin
        valid[idx] <= 1'b0;
        total <= total - CNT_W'(1);
      end
      if (cmd.ins) begin
        if (free_ok) begin
          valid[free] <= 1'b1;
          total <= total + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      key_q <= image_key;
      hdl_q <= new_handle;
      mn_have <= 1'b0;
      free_ok <= 1'b0;
      removed <= '0;
    end
    if (cmd.scan_ck) begin
      if (valid[idx]) begin
        if (!mn_have || rdata.uses < mn) begin
          mn <= rdata.uses;
          mn_have <= 1'b1;
        end
      end else if (!free_ok) begin
        free <= idx;
        free_ok <= 1'b1;
      end
    end
    if (cmd.ev_ck && valid[idx] && rdata.frame != fn && rdata.uses == mn) begin
      removed <= removed + CNT_W'(1);
      if (!free_ok) begin
        free <= idx;
        free_ok <= 1'b1;
      end
    end
    if (cmd.simple) begin
      hit <= 1'b0;
      handle_out <= '0;
      stored <= 1'b0;
      evicted_count <= (req_type == REQ_CLEAR) ? sat_evict(total) : 9'd0;
    end
    if (cmd.hit_wr) begin
      hit <= 1'b1;
      handle_out <= rdata.handle;
      stored <= 1'b0;
      evicted_count <= 9'd0;
    end
    if (cmd.ins) begin
      hit <= 1'b0;
      handle_out <= hdl_q;
      stored <= free_ok;
      evicted_count <= sat_evict(removed);
    end
  end
endmodule

// ===== design/frame_pinned_lfu_image_cache.sv =====
`timescale 1ns / 1ps
// Frame pinned LFU image handle cache, top level.
// Depends on flc_pkg, flc_ctrl, flc_dp, flc_ram and assert_macros.svh.
//
// A request transaction is taken when start is high and busy is low.
// req_type selects access by image_key, new frame, or clear all.
// Each request gives one result, shown for one cycle with done high;
// the receiver cannot stall, so it must take the result in that cycle.
// New frame, clear and the unused code finish without leaving the idle
// state, result on the next cycle, and busy stays low.
// An access walks the entry RAM one entry at a time (read then
// compare) through its single read port: a hit ends the scan at the
// key's slot, a miss scans all N entries, and a miss on a full table
// adds an eviction pass over all N entries (N = 256 entries).
// Reset clears all valid bits, the entry count and the frame number at
// once; no clearing pass is needed.
module frame_pinned_lfu_image_cache import flc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         req_type,
  input  logic [63:0]        image_key,
  input  logic signed [16:0] new_handle,
  output logic               done,
  output logic               hit,
  output logic signed [16:0] handle_out,
  output logic [8:0]         evicted_count,
  output logic               stored
);
`include "assert_macros.svh"
  cmd_t cmd;
  sts_t sts;
  logic [CNT_W-1:0] total;

  flc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .sts(sts), .cmd(cmd), .busy(busy)
  );

  flc_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .req_type(req_type), .image_key(image_key), .new_handle(new_handle),
    .done(done), .hit(hit), .handle_out(handle_out),
    .evicted_count(evicted_count), .stored(stored), .total(total)
  );

  `FLC_ASSERT_IMP(a_done_idle, done, !busy)
  `FLC_ASSERT_IMP(a_hit_clean, done && hit, !stored && evicted_count == 9'd0)
  `FLC_ASSERT_ALW(a_total_max, total <= CNT_W'(CACHE_ENTRIES))
endmodule
